[sv/fixed_point_alu_macros.svh]
// Assertion macros for the fixed-point ALU
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Check an implication on every clock edge outside reset
`define FPA_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fixed_point_alu assertion failed");

// Check that a condition never holds outside reset
`define FPA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fixed_point_alu assertion failed");

`endif

[sv/fpa_pkg.sv]
// Shared types, codes and helpers for the fixed-point ALU
`default_nettype none
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  // quotient bits resolved by the divider chain
  localparam int QUO_BITS = 34;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_LT = 4'd4;
  localparam logic [3:0] OP_GT = 4'd5;
  localparam logic [3:0] OP_LE = 4'd6;
  localparam logic [3:0] OP_GE = 4'd7;
  localparam logic [3:0] OP_EQ = 4'd8;
  localparam logic [3:0] OP_NE = 4'd9;
  localparam logic [3:0] OP_MIN = 4'd10;
  localparam logic [3:0] OP_MAX = 4'd11;
  localparam logic [3:0] OP_INC = 4'd12;
  localparam logic [3:0] OP_DEC = 4'd13;
  localparam logic [3:0] OP_FROM_INT = 4'd14;
  localparam logic [3:0] OP_TO_INT = 4'd15;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // divider state handed from cell to cell
  typedef struct packed {
    logic valid;
    logic [31:0] rem;
    logic [QUO_BITS-1:0] num;
    logic [QUO_BITS-1:0] quo;
    logic [31:0] den;
  } div_t;

  // transaction data that rides alongside the divider
  typedef struct packed {
    logic [3:0] op;
    logic signed [31:0] res;
    logic cmp;
    logic [1:0] st;
    logic signed [63:0] prod;
    logic neg;
    logic div_ovf;
  } side_t;

  typedef struct packed {
    logic ovf;
    logic signed [31:0] val;
  } sat_t;

  // clamp a 64-bit signed value to 32 bits
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      s.ovf = 1'b1;
      s.val = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      s.ovf = 1'b1;
      s.val = -32'sh8000_0000;
    end else begin
      s.ovf = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[sv/fpa_div_cell.sv]
// One restoring-division cell: resolves one quotient bit per cycle
`default_nettype none
module fpa_div_cell
  import fpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire div_t  div_in,
  input  wire side_t side_in,
  output div_t       div_out,
  output side_t      side_out
);

  div_t  div_r, div_nxt;
  side_t side_r;
  logic [32:0] trial;
  logic        ge;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {div_in.rem, div_in.num[QUO_BITS-1]};
    ge = trial >= {1'b0, div_in.den};
    div_nxt = div_in;
    div_nxt.rem = ge ? 32'(trial - {1'b0, div_in.den}) : trial[31:0];
    div_nxt.num = {div_in.num[QUO_BITS-2:0], 1'b0};
    div_nxt.quo = {div_in.quo[QUO_BITS-2:0], ge};
  end

  // advance the transaction one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else begin
      div_r.valid <= div_nxt.valid;
    end
    div_r.rem <= div_nxt.rem;
    div_r.num <= div_nxt.num;
    div_r.quo <= div_nxt.quo;
    div_r.den <= div_nxt.den;
    side_r <= side_in;
  end

  assign div_out = div_r;
  assign side_out = side_r;

endmodule
`default_nettype wire

[sv/fixed_point_alu.sv]
// Top level of the pipelined fixed-point ALU
//
// Command-style block. Drive in_opcode, in_operand_a and in_operand_b with
// start high; the transaction is taken at that edge when busy is low. busy
// is always low, so one transaction can be issued every cycle.
// Each transaction gives one result: out_valid is high for exactly one
// cycle with out_result_value, out_compare_true and out_status.
// Every opcode passes through the same stages: one operand preparation stage
// (which also holds the 32x32 multiplier), 34 divider cells that each
// resolve one quotient bit, and one rounding and saturation stage.
// Throughput is one transaction per cycle; results leave in issue order.
// Synchronous reset (rst_n low) empties the pipeline; nothing in flight
// is reported. The receiver cannot stall, so results must be taken in the
// cycle they appear.
// Multiply and divide round to nearest with ties away from zero; overflow
// saturates with status 1, divide by zero saturates by the dividend's sign
// with status 2.
`default_nettype none
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_opcode,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_valid,
  output logic signed [31:0]      out_result_value,
  output logic                    out_compare_true,
  output logic [1:0]              out_status
);

  localparam int LAT = QUO_BITS + 2;
  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  // ---------------- preparation stage ----------------
  div_t  prep_div_r;
  side_t prep_side_r;
  div_t  prep_div_nxt;
  side_t prep_side_nxt;

  logic        accept;
  logic [32:0] abs_a;
  logic [32:0] abs_b;
  logic [63:0] n2;
  logic signed [63:0] a64;
  logic signed [63:0] b64;
  sat_t        sat_s;

  assign accept = start && !busy;
  assign busy = 1'b0;

  always_comb begin
    a64 = 64'(in_operand_a);
    b64 = 64'(in_operand_b);
    abs_a = in_operand_a[31] ? 33'(-{in_operand_a[31], in_operand_a})
                             : {1'b0, in_operand_a};
    abs_b = in_operand_b[31] ? 33'(-{in_operand_b[31], in_operand_b})
                             : {1'b0, in_operand_b};
    n2 = 64'(abs_a) << (FRAC_BITS + 1);
    sat_s = '0;

    prep_div_nxt.valid = accept;
    prep_div_nxt.den = abs_b[31:0];
    prep_div_nxt.rem = {2'b00, n2[63:QUO_BITS]};
    prep_div_nxt.num = n2[QUO_BITS-1:0];
    prep_div_nxt.quo = '0;

    prep_side_nxt.op = in_opcode;
    prep_side_nxt.res = '0;
    prep_side_nxt.cmp = 1'b0;
    prep_side_nxt.st = ST_OK;
    prep_side_nxt.prod = in_operand_a * in_operand_b;
    prep_side_nxt.neg = in_operand_a[31] ^ in_operand_b[31];
    prep_side_nxt.div_ovf = {2'b00, n2[63:QUO_BITS]} >= abs_b[31:0];

    // settle every opcode that needs no rounding here
    unique case (in_opcode)
      OP_ADD: sat_s = sat64(a64 + b64);
      OP_SUB: sat_s = sat64(a64 - b64);
      OP_INC: sat_s = sat64(a64 + 64'sd1);
      OP_DEC: sat_s = sat64(a64 - 64'sd1);
      OP_FROM_INT: sat_s = sat64(a64 <<< FRAC_BITS);
      OP_TO_INT: sat_s.val = in_operand_a >>> FRAC_BITS;
      OP_MIN: sat_s.val = (in_operand_a <= in_operand_b) ? in_operand_a : in_operand_b;
      OP_MAX: sat_s.val = (in_operand_a >= in_operand_b) ? in_operand_a : in_operand_b;
      OP_LT: prep_side_nxt.cmp = in_operand_a < in_operand_b;
      OP_GT: prep_side_nxt.cmp = in_operand_a > in_operand_b;
      OP_LE: prep_side_nxt.cmp = in_operand_a <= in_operand_b;
      OP_GE: prep_side_nxt.cmp = in_operand_a >= in_operand_b;
      OP_EQ: prep_side_nxt.cmp = in_operand_a == in_operand_b;
      OP_NE: prep_side_nxt.cmp = in_operand_a != in_operand_b;
      OP_DIV: begin
        if (in_operand_b == 32'sd0) begin
          sat_s.val = in_operand_a[31] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
          prep_side_nxt.st = ST_DIVZ;
        end
      end
      default: sat_s = '0;
    endcase
    prep_side_nxt.res = sat_s.val;
    if (sat_s.ovf) begin
      prep_side_nxt.st = ST_OVF;
    end
  end

  // hold the prepared transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_div_r.valid <= 1'b0;
    end else begin
      prep_div_r.valid <= prep_div_nxt.valid;
    end
    prep_div_r.rem <= prep_div_nxt.rem;
    prep_div_r.num <= prep_div_nxt.num;
    prep_div_r.quo <= prep_div_nxt.quo;
    prep_div_r.den <= prep_div_nxt.den;
    prep_side_r <= prep_side_nxt;
  end

  // ---------------- divider chain ----------------
  div_t  chain_div [QUO_BITS+1];
  side_t chain_side [QUO_BITS+1];

  assign chain_div[0] = prep_div_r;
  assign chain_side[0] = prep_side_r;

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .div_in  (chain_div[i]),
      .side_in (chain_side[i]),
      .div_out (chain_div[i+1]),
      .side_out(chain_side[i+1])
    );
  end

  // ---------------- rounding and saturation ----------------
  div_t  tail_div;
  side_t tail_side;
  logic [63:0] mag_p;
  logic [63:0] q_mul;
  logic [34:0] q_div;
  logic signed [63:0] v64;
  sat_t  fin_s;
  logic                out_valid_r;
  logic signed [31:0]  res_r, res_nxt;
  logic                cmp_r;
  logic [1:0]          st_r, st_nxt;

  assign tail_div = chain_div[QUO_BITS];
  assign tail_side = chain_side[QUO_BITS];

  always_comb begin
    mag_p = tail_side.prod[63] ? 64'(-tail_side.prod) : 64'(tail_side.prod);
    q_mul = (mag_p + HALF) >> FRAC_BITS;
    q_div = (35'(tail_div.quo) + 35'd1) >> 1;
    res_nxt = tail_side.res;
    st_nxt = tail_side.st;
    v64 = '0;
    fin_s = '0;
    if (tail_side.op == OP_MUL) begin
      v64 = tail_side.prod[63] ? -$signed(q_mul) : $signed(q_mul);
      fin_s = sat64(v64);
      res_nxt = fin_s.val;
      st_nxt = fin_s.ovf ? ST_OVF : ST_OK;
    end else if (tail_side.op == OP_DIV && tail_side.st != ST_DIVZ) begin
      v64 = tail_side.neg ? -$signed(64'(q_div)) : $signed(64'(q_div));
      fin_s = sat64(v64);
      if (tail_side.div_ovf) begin
        fin_s.ovf = 1'b1;
        fin_s.val = tail_side.neg ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      res_nxt = fin_s.val;
      st_nxt = fin_s.ovf ? ST_OVF : ST_OK;
    end
  end

  // register the result for one strobe cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail_div.valid;
    end
    res_r <= res_nxt;
    cmp_r <= tail_side.cmp;
    st_r <= st_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_result_value = res_r;
  assign out_compare_true = cmp_r;
  assign out_status = st_r;

  `include "fixed_point_alu_macros.svh"

  `FPA_ASSERT_IMP(a_latency, accept, ##LAT out_valid)
  `FPA_ASSERT_IMP(a_cmp_clean, out_valid && out_compare_true,
                  out_status == ST_OK && out_result_value == 32'sd0)
  `FPA_ASSERT_NEVER(a_status_code, out_valid && out_status == 2'd3)

endmodule
`default_nettype wire
